@@ hdl/dtnp_pkg.sv @@
// types and constants shared by the decimal text parser modules
`timescale 1ns / 1ps

package dtnp_pkg;

  localparam logic [15:0] CH_MINUS   = 16'd45;
  localparam logic [15:0] CH_DASH    = 16'd150;
  localparam logic [15:0] CH_BLANK   = 16'd32;
  localparam logic [15:0] CH_POINT   = 16'd46;
  localparam logic [15:0] CH_ZERO    = 16'd48;
  localparam logic [15:0] CH_NINE    = 16'd57;
  localparam logic [15:0] CH_DOLLAR  = 16'd36;
  localparam logic [15:0] CH_POUND   = 16'd163;
  localparam logic [15:0] CH_CURRENCY = 16'd164;
  localparam logic [15:0] CH_YEN     = 16'd165;
  localparam logic [15:0] CH_EURO    = 16'd8364;
  localparam logic [15:0] CH_COMMA   = 16'd44;
  localparam logic [15:0] CH_PERCENT = 16'd37;
  localparam logic [15:0] CH_CENT    = 16'd162;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [62:0] ACC_MAX   = {63{1'b1}};
  localparam logic [7:0]  SCALE_MAX = 8'd255;

  typedef struct packed {
    logic [62:0] acc;
    logic        neg;
    logic [1:0]  points;
    logic [7:0]  scale;
    logic        closed;
    logic        rejected;
    logic        overflow;
  } parse_state_t;

  typedef struct packed {
    logic signed [63:0] mantissa;
    logic [7:0]         decimal_scale;
    logic [1:0]         status;
  } parse_result_t;

endpackage

@@ hdl/dtnp_if.sv @@
// handshake interfaces for the character input and the parsed number output
`timescale 1ns / 1ps

interface dtnp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        last;
  logic        is_empty;

  modport source (output valid, output char_code, output last, output is_empty, input ready);
  modport sink (input valid, input char_code, input last, input is_empty, output ready);
endinterface

interface dtnp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] mantissa;
  logic [7:0]         decimal_scale;
  logic [1:0]         status;

  modport source (output valid, output mantissa, output decimal_scale, output status,
                  input ready);
  modport sink (input valid, input mantissa, input decimal_scale, input status,
                output ready);
endinterface

@@ hdl/decimal_text_number_parser_core.sv @@
// Decimal text parser: one 16-bit character per cycle in, one number per string out.
// Characters are taken one per clock except while stalled as below. Each accepted character is
// held in an input register, the parse state is updated from it by a single
// multiply-by-ten-and-add step, and on the last character (or an empty-string marker)
// the signed mantissa, decimal scale and status go to an output register. The input side
// keeps taking characters while a result waits; it stalls only when a new result is due and
// the output register still holds an untaken one.
`timescale 1ns / 1ps

module decimal_text_number_parser_core #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  dtnp_in_if.sink    in_i,
  dtnp_out_if.source out_o
);
  import dtnp_pkg::*;

  // input register
  logic        in_vld_q;
  logic [15:0] char_q;
  logic        last_q;
  logic        empty_q;

  parse_state_t              state_q, state_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [POSITION_WIDTH-1:0] blank_q, blank_d;

  logic          out_vld_q;
  parse_result_t res_q;
  parse_result_t res_d;
  logic          emit;
  logic          s1_fire;
  logic          s1_free;

  dtnp_step #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_step (
    .state_i    (state_q),
    .pos_i      (pos_q),
    .blank_i    (blank_q),
    .char_code_i(char_q),
    .last_i     (last_q),
    .is_empty_i (empty_q),
    .state_o    (state_d),
    .pos_o      (pos_d),
    .blank_o    (blank_d),
    .emit_o     (emit),
    .result_o   (res_d)
  );

  // the held character moves on unless its result would find the output full
  assign s1_fire = in_vld_q && (!emit || !out_vld_q || out_o.ready);
  assign s1_free = !in_vld_q || s1_fire;
  assign in_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s1_free) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_free) begin
      char_q  <= in_i.char_code;
      last_q  <= in_i.last;
      empty_q <= in_i.is_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      pos_q   <= '0;
      blank_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      blank_q <= blank_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.mantissa      = res_q.mantissa;
  assign out_o.decimal_scale = res_q.decimal_scale;
  assign out_o.status        = res_q.status;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.status == ST_OK || res_q.status == ST_REJECTED ||
                   res_q.status == ST_OVERFLOW))
    else $error("undefined status code on output");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.status == ST_REJECTED) |->
      (res_q.mantissa == '0 && res_q.decimal_scale == '0))
    else $error("rejected string with nonzero value");

  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.status == ST_OVERFLOW) |->
      (res_q.mantissa == {1'b0, ACC_MAX} || res_q.mantissa == -{1'b0, ACC_MAX}))
    else $error("overflow status without saturated mantissa");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |=> (state_q == '0 && pos_q == '0 && blank_q == '0))
    else $error("parse state not cleared after result");

  a_result_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |=> out_vld_q)
    else $error("result lost at output register");

endmodule

@@ hdl/dtnp_step.sv @@
// per-character parse update and result formation
`timescale 1ns / 1ps

module dtnp_step #(
  parameter int POSITION_WIDTH = 16
) (
  input  dtnp_pkg::parse_state_t    state_i,
  input  logic [POSITION_WIDTH-1:0] pos_i,
  input  logic [POSITION_WIDTH-1:0] blank_i,
  input  logic [15:0]               char_code_i,
  input  logic                      last_i,
  input  logic                      is_empty_i,
  output dtnp_pkg::parse_state_t    state_o,
  output logic [POSITION_WIDTH-1:0] pos_o,
  output logic [POSITION_WIDTH-1:0] blank_o,
  output logic                      emit_o,
  output dtnp_pkg::parse_result_t   result_o
);
  import dtnp_pkg::*;

  parse_state_t              upd;
  logic [POSITION_WIDTH-1:0] pos_upd;
  logic [POSITION_WIDTH-1:0] blank_upd;
  logic [66:0]               acc_x10;
  logic [8:0]                scale_p1;
  logic [8:0]                scale_p2;
  logic [63:0]               magnitude;

  // acc * 10 + digit, overflow shows in the top bits
  assign acc_x10 = ({4'b0, state_i.acc} << 3) + ({4'b0, state_i.acc} << 1)
                   + {63'b0, char_code_i[3:0] - CH_ZERO[3:0]};
  assign scale_p1 = {1'b0, state_i.scale} + 9'd1;
  assign scale_p2 = {1'b0, state_i.scale} + 9'd2;
  assign magnitude = {1'b0, upd.acc};

  always_comb begin
    upd       = state_i;
    pos_upd   = pos_i;
    blank_upd = blank_i;
    if (!state_i.rejected) begin
      case (char_code_i) inside
        CH_MINUS, CH_DASH: begin
          if (pos_i == '0 || pos_i == blank_i) begin
            upd.neg = 1'b1;
          end else begin
            upd.rejected = 1'b1;
          end
        end
        CH_BLANK: begin
          if (blank_i != '1) begin
            blank_upd = blank_i + 1'b1;
          end
          if (state_i.acc != '0 || state_i.neg || state_i.points != 2'd0) begin
            upd.closed = 1'b1;
          end
        end
        CH_POINT: begin
          if (state_i.points != 2'd0) begin
            upd.points   = 2'd2;
            upd.rejected = 1'b1;
          end else begin
            upd.points = 2'd1;
          end
        end
        CH_DOLLAR, CH_POUND, CH_CURRENCY, CH_YEN, CH_EURO, CH_COMMA: begin
        end
        CH_PERCENT, CH_CENT: begin
          upd.closed = 1'b1;
          upd.scale  = scale_p2[8] ? SCALE_MAX : scale_p2[7:0];
        end
        [CH_ZERO:CH_NINE]: begin
          if (state_i.closed) begin
            upd.rejected = 1'b1;
          end else begin
            if (acc_x10[66:63] != 4'd0) begin
              upd.acc      = ACC_MAX;
              upd.overflow = 1'b1;
            end else begin
              upd.acc = acc_x10[62:0];
            end
            if (state_i.points != 2'd0) begin
              upd.scale = scale_p1[8] ? SCALE_MAX : scale_p1[7:0];
            end
          end
        end
        default: begin
          upd.rejected = 1'b1;
        end
      endcase
      if (pos_i != '1) begin
        pos_upd = pos_i + 1'b1;
      end
    end
  end

  always_comb begin
    emit_o   = is_empty_i || last_i;
    result_o = '0;
    if (is_empty_i) begin
      result_o.status = ST_OK;
    end else if (upd.rejected) begin
      result_o.status = ST_REJECTED;
    end else begin
      result_o.mantissa      = upd.neg ? -magnitude : magnitude;
      result_o.decimal_scale = upd.scale;
      result_o.status        = upd.overflow ? ST_OVERFLOW : ST_OK;
    end
    // a finished string leaves the parser cleared for the next one
    if (emit_o) begin
      state_o = '0;
      pos_o   = '0;
      blank_o = '0;
    end else begin
      state_o = upd;
      pos_o   = pos_upd;
      blank_o = blank_upd;
    end
  end

endmodule

@@ sim/decimal_text_number_parser_core_test.sv @@
// testbench for the decimal text parser core: directed and random strings against a predictor
`timescale 1ns / 1ps

module decimal_text_number_parser_core_test;
  import dtnp_pkg::*;

  localparam int          POS_W       = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam int          RANDOM_CHARS = 100;
  localparam int          TAIL_CHARS   = 40;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          CYCLE_LIMIT  = 600000;

  logic clk_i;
  logic rst_ni;

  dtnp_in_if  char_if ();
  dtnp_out_if number_if ();

  decimal_text_number_parser_core #(
    .POSITION_WIDTH(POS_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_if),
    .out_o (number_if)
  );

  // predictor copy of the parse state
  logic [62:0]      acc_q;
  logic             neg_q;
  logic [1:0]       points_q;
  logic [7:0]       scale_q;
  logic [POS_W-1:0] position_q;
  logic [POS_W-1:0] blanks_q;
  logic             closed_q;
  logic             rejected_q;
  logic             overflow_q;

  parse_result_t expected_numbers[$];
  logic [15:0]   pending_text[$];

  int  error_count;
  int  chars_sent;
  int  cycle_count;
  int  hold_requests;
  int  holds_done;
  bit  idle_on;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic clear_parse();
    acc_q      = '0;
    neg_q      = 1'b0;
    points_q   = '0;
    scale_q    = '0;
    position_q = '0;
    blanks_q   = '0;
    closed_q   = 1'b0;
    rejected_q = 1'b0;
    overflow_q = 1'b0;
  endtask

  task automatic add_scale(input int n);
    int s;
    s = int'(scale_q) + n;
    scale_q = (s > int'(SCALE_MAX)) ? SCALE_MAX : 8'(s);
  endtask

  // advance the predicted state by one character and queue a number on the last one or on an empty-string marker
  task automatic parse_char(input logic [15:0] c, input logic lst, input logic emp);
    parse_result_t res;
    logic [63:0]   d;
    logic [63:0]   acc_limit;
    res = '0;
    if (emp) begin
      expected_numbers.push_back(res);
      clear_parse();
      return;
    end
    if (!rejected_q) begin
      case (c)
        CH_MINUS, CH_DASH: begin
          // sign only while everything so far was blank
          if (position_q == '0 || position_q == blanks_q) neg_q = 1'b1;
          else rejected_q = 1'b1;
        end
        CH_BLANK: begin
          if (blanks_q != POS_MAX) blanks_q = blanks_q + 1'b1;
          if (acc_q != '0 || neg_q || points_q != '0) closed_q = 1'b1;
        end
        CH_POINT: begin
          if (points_q != '0) begin
            points_q   = 2'd2;
            rejected_q = 1'b1;
          end else begin
            points_q = 2'd1;
          end
        end
        CH_DOLLAR, CH_POUND, CH_CURRENCY, CH_YEN, CH_EURO, CH_COMMA: ;
        CH_PERCENT, CH_CENT: begin
          closed_q = 1'b1;
          add_scale(2);
        end
        default: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            if (closed_q) begin
              rejected_q = 1'b1;
            end else begin
              d = 64'(c - CH_ZERO);
              acc_limit = ({1'b0, ACC_MAX} - d) / 64'd10;
              if ({1'b0, acc_q} > acc_limit) begin
                acc_q      = ACC_MAX;
                overflow_q = 1'b1;
              end else begin
                acc_q = 63'({1'b0, acc_q} * 64'd10 + d);
              end
              if (points_q != '0) add_scale(1);
            end
          end else begin
            rejected_q = 1'b1;
          end
        end
      endcase
      if (position_q != POS_MAX) position_q = position_q + 1'b1;
    end
    if (!lst) return;
    if (rejected_q) begin
      res.status = ST_REJECTED;
    end else begin
      res.mantissa      = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
      res.decimal_scale = scale_q;
      res.status        = overflow_q ? ST_OVERFLOW : ST_OK;
    end
    expected_numbers.push_back(res);
    clear_parse();
  endtask

  // offer one character, wait for its transaction, then predict
  task automatic send_char(input logic [15:0] c, input logic lst, input logic emp);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.last      <= lst;
    char_if.is_empty  <= emp;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
    parse_char(c, lst, emp);
  endtask

  // send the built-up string, or an empty-string marker if nothing was built
  task automatic send_pending();
    int n;
    n = pending_text.size();
    if (n == 0) begin
      send_char(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      for (int i = 0; i < n; i++) send_char(pending_text[i], i == n - 1, 1'b0);
    end
    pending_text.delete();
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_text.push_back(16'(s[i]));
  endtask

  task automatic send_text(input string s);
    append_text(s);
    send_pending();
  endtask

  function automatic logic [15:0] pick_currency();
    case ($urandom_range(0, 4))
      0:       return CH_DOLLAR;
      1:       return CH_POUND;
      2:       return CH_CURRENCY;
      3:       return CH_YEN;
      default: return CH_EURO;
    endcase
  endfunction

  function automatic logic [15:0] random_digit();
    return CH_ZERO + 16'($urandom_range(0, 9));
  endfunction

  function automatic logic [15:0] noise_char();
    case ($urandom_range(0, 11))
      0:       return CH_MINUS;
      1:       return CH_DASH;
      2:       return CH_POINT;
      3:       return CH_BLANK;
      4:       return CH_PERCENT;
      5:       return CH_CENT;
      6:       return random_digit();
      7:       return 16'($urandom_range(97, 122));
      8:       return pick_currency();
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // a well-formed number with random content
  task automatic append_number();
    int n;
    repeat ($urandom_range(0, 2)) pending_text.push_back(CH_BLANK);
    if ($urandom_range(0, 2) == 0) pending_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_DASH);
    if ($urandom_range(0, 3) == 0) pending_text.push_back(pick_currency());
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      if (k != 0 && $urandom_range(0, 5) == 0) pending_text.push_back(CH_COMMA);
      pending_text.push_back(random_digit());
    end
    if ($urandom_range(0, 1) == 0) begin
      pending_text.push_back(CH_POINT);
      repeat ($urandom_range(0, 4)) pending_text.push_back(random_digit());
    end
    if ($urandom_range(0, 4) == 0) pending_text.push_back($urandom_range(0, 1) ? CH_PERCENT : CH_CENT);
    repeat ($urandom_range(0, 2)) pending_text.push_back(CH_BLANK);
  endtask

  task automatic append_random_string();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      append_number();
    end else if (kind < 17) begin
      append_number();
      pending_text.insert($urandom_range(0, pending_text.size()), noise_char());
    end else if (kind < 19) begin
      repeat ($urandom_range(1, 5)) pending_text.push_back(noise_char());
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int n;
    number_if.ready <= 1'b0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        number_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_done = hold_requests;
        number_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        number_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        number_if.ready <= 1'b1;
      end else begin
        number_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    parse_result_t exp_num;
    if (rst_ni && number_if.valid && number_if.ready) begin
      if (expected_numbers.size() == 0) begin
        $display("%0t: unexpected number mantissa %0d scale %0d status %0d", $realtime,
                 number_if.mantissa, number_if.decimal_scale, number_if.status);
        error_count++;
      end else begin
        exp_num = expected_numbers.pop_front();
        if (number_if.mantissa !== exp_num.mantissa) begin
          $display("%0t: mantissa expected %0d actual %0d", $realtime, exp_num.mantissa,
                   number_if.mantissa);
          error_count++;
        end
        if (number_if.decimal_scale !== exp_num.decimal_scale) begin
          $display("%0t: decimal_scale expected %0d actual %0d", $realtime,
                   exp_num.decimal_scale, number_if.decimal_scale);
          error_count++;
        end
        if (number_if.status !== exp_num.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_num.status,
                   number_if.status);
          error_count++;
        end
      end
    end
  end

  task automatic test_formats();
    send_text("0");
    send_text("42");
    send_text("-17");
    send_text("  -3.25  ");
    pending_text.push_back(CH_DASH);
    send_text("8.5");
    send_text("$1,234.56");
    pending_text.push_back(CH_EURO);
    pending_text.push_back(CH_POUND);
    pending_text.push_back(CH_YEN);
    pending_text.push_back(CH_CURRENCY);
    send_text("99");
    send_text("12%");
    append_text("5.5");
    pending_text.push_back(CH_CENT);
    send_pending();
    send_text("0 1");
    send_text(".");
  endtask

  task automatic test_rejects();
    send_text("1.2.3");
    send_text("12 3");
    send_text("1-");
    send_text("5x9 7");
    send_text("1% 2");
    pending_text.push_back(16'h0000);
    send_pending();
    pending_text.push_back(16'hFFFF);
    send_pending();
  endtask

  task automatic test_empty_marker();
    send_char(16'hFFFF, 1'b1, 1'b1);
    send_char(16'h0000, 1'b0, 1'b1);
    // a marker in the middle of a string drops what came before it
    send_char(CH_ZERO + 16'd1, 1'b0, 1'b0);
    send_char(CH_ZERO + 16'd2, 1'b0, 1'b0);
    send_char(CH_ZERO + 16'd7, 1'b0, 1'b1);
    send_text("3");
  endtask

  task automatic test_limits();
    send_text("-");
    send_text("-0.00");
    send_text("9999999999999999999");
    send_text("-99999999999999999999999");
    send_text("99999999999999999999x");
    send_text("9223372036854775807");
    append_text("1");
    repeat (130) pending_text.push_back(CH_PERCENT);
    send_pending();
    append_text("0.");
    repeat (260) pending_text.push_back(CH_ZERO);
    send_pending();
  endtask

  task automatic test_random_strings(input int char_target);
    int start;
    start = chars_sent;
    while (chars_sent - start < char_target) begin
      append_random_string();
      send_pending();
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    repeat (40) begin
      pending_text.push_back(random_digit());
      send_pending();
    end
  endtask

  initial begin : stimulus
    error_count   = 0;
    chars_sent    = 0;
    cycle_count   = 0;
    hold_requests = 0;
    idle_on       = 1'b1;
    clear_parse();
    rst_ni            <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    char_if.last      <= 1'b0;
    char_if.is_empty  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_formats();
    test_rejects();
    test_empty_marker();
    test_limits();
    test_random_strings(RANDOM_CHARS);
    idle_on = 1'b0;
    test_backpressure();
    test_random_strings(TAIL_CHARS);

    char_if.valid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
